/* rtl/iprc_pkg.sv */
// Package for the ICMP probe reply classifier: constants, codes and types.
`default_nettype none

package iprc_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 1024;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] CFG_IDENT  = 2'd0;
    localparam logic [1:0] CFG_SEQ    = 2'd1;
    localparam logic [1:0] CFG_TARGET = 2'd2;

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    localparam int ICMP_HDR_BYTES = 8;
    localparam int SRC_ADDR_POS   = 12;
    localparam int DST_ADDR_POS   = 16;
    localparam int IP_ADDR_BYTES  = 4;

    localparam int ID_HI_OFS  = 4;
    localparam int ID_LO_OFS  = 5;
    localparam int SEQ_HI_OFS = 6;
    localparam int SEQ_LO_OFS = 7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OTHER    = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

endpackage

`default_nettype wire

/* rtl/icmp_probe_reply_classifier.sv */
// Top level of the ICMP probe reply classifier: byte parser and result register.
// The last byte passes the input register and then the result register, which holds the result.
// Throughput: one byte item per cycle; an input register and a result register part the sides.
// A pending result only stalls the input when the byte behind it is itself a last byte.
// Reset (synchronous, active low) clears the configuration, the parse state and both valids.
`default_nettype none

module icmp_probe_reply_classifier #(
    parameter int MAX_PACKET_BYTES = iprc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [iprc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [iprc_pkg::DATA_W-1:0] pwdata,
    output logic      [iprc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_last_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_matched,
    output logic                             o_reply_kind,
    output logic      [31:0]                 o_responder_address,
    output logic      [31:0]                 o_local_address,
    output logic                             o_reached_target,
    output logic      [1:0]                  o_status
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int OFS_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

    // configuration
    logic [15:0] r_exp_ident;
    logic [15:0] r_exp_seq;
    logic [31:0] r_target;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ident <= '0;
            r_exp_seq   <= '0;
            r_target    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                iprc_pkg::CFG_IDENT:  r_exp_ident <= pwdata[15:0];
                iprc_pkg::CFG_SEQ:    r_exp_seq   <= pwdata[15:0];
                iprc_pkg::CFG_TARGET: r_target    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            iprc_pkg::CFG_IDENT:  prdata = {16'b0, r_exp_ident};
            iprc_pkg::CFG_SEQ:    prdata = {16'b0, r_exp_seq};
            iprc_pkg::CFG_TARGET: prdata = r_target;
            default:              prdata = '0;
        endcase
    end

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       s1_go;
    logic       r_out_valid;

    assign s1_go      = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
        end
    end

    // parse state
    logic [CNT_W-1:0] r_pos;
    logic [5:0]       r_outer;
    logic [5:0]       r_inner;
    logic [7:0]       r_type;
    logic [15:0]      r_ident;
    logic [15:0]      r_seq;
    logic [31:0]      r_src;
    logic [31:0]      r_dst;
    logic             r_done;

    logic [CNT_W-1:0] n_pos;
    logic [5:0]       n_outer;
    logic [5:0]       n_inner;
    logic [7:0]       n_type;
    logic [15:0]      n_ident;
    logic [15:0]      n_seq;
    logic [31:0]      n_src;
    logic [31:0]      n_dst;
    logic             n_done;

    logic [OFS_W-1:0] p;
    logic [OFS_W-1:0] h;
    logic [OFS_W-1:0] hb8;
    logic [OFS_W-1:0] ip;
    logic [OFS_W-1:0] rel;
    logic             take;

    always_comb begin
        n_pos   = r_pos;
        n_outer = r_outer;
        n_inner = r_inner;
        n_type  = r_type;
        n_ident = r_ident;
        n_seq   = r_seq;
        n_src   = r_src;
        n_dst   = r_dst;
        n_done  = r_done;
        p       = OFS_W'(r_pos);
        h       = '0;
        hb8     = '0;
        ip      = '0;
        rel     = '0;
        take    = 1'b0;
        if (r_pos < MAX_CNT) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == '0) begin
                n_outer = {r_s1_byte[3:0], 2'b00};
            end
            h   = OFS_W'(n_outer);
            hb8 = h + OFS_W'(iprc_pkg::ICMP_HDR_BYTES);

            if (p >= OFS_W'(iprc_pkg::SRC_ADDR_POS) &&
                p <  OFS_W'(iprc_pkg::SRC_ADDR_POS + iprc_pkg::IP_ADDR_BYTES)) begin
                unique case (p[1:0])
                    2'd0: n_src[31:24] = r_s1_byte;
                    2'd1: n_src[23:16] = r_s1_byte;
                    2'd2: n_src[15:8]  = r_s1_byte;
                    2'd3: n_src[7:0]   = r_s1_byte;
                endcase
            end
            if (p >= OFS_W'(iprc_pkg::DST_ADDR_POS) &&
                p <  OFS_W'(iprc_pkg::DST_ADDR_POS + iprc_pkg::IP_ADDR_BYTES)) begin
                unique case (p[1:0])
                    2'd0: n_dst[31:24] = r_s1_byte;
                    2'd1: n_dst[23:16] = r_s1_byte;
                    2'd2: n_dst[15:8]  = r_s1_byte;
                    2'd3: n_dst[7:0]   = r_s1_byte;
                endcase
            end

            if (p == h) begin
                n_type = r_s1_byte;
            end

            if (p > h && r_type == iprc_pkg::TYPE_ECHO_REPLY) begin
                take = 1'b1;
                rel  = p - h;
            end else if (p > h && r_type == iprc_pkg::TYPE_TIME_EXCEEDED) begin
                if (p == hb8) begin
                    n_inner = {r_s1_byte[3:0], 2'b00};
                end
                ip = hb8 + OFS_W'(n_inner);
                if (p > hb8 && p >= ip) begin
                    take = 1'b1;
                    rel  = p - ip;
                end
            end

            if (take) begin
                priority if (rel == OFS_W'(iprc_pkg::ID_HI_OFS)) begin
                    n_ident[15:8] = r_s1_byte;
                end else if (rel == OFS_W'(iprc_pkg::ID_LO_OFS)) begin
                    n_ident[7:0] = r_s1_byte;
                end else if (rel == OFS_W'(iprc_pkg::SEQ_HI_OFS)) begin
                    n_seq[15:8] = r_s1_byte;
                end else if (rel == OFS_W'(iprc_pkg::SEQ_LO_OFS)) begin
                    n_seq[7:0] = r_s1_byte;
                    n_done     = 1'b1;
                end else begin
                end
            end
        end
    end

    // classification on the last byte
    iprc_pkg::t_status res_status;
    logic              res_kind;
    logic              res_short;

    assign res_short = OFS_W'(n_pos) <
                       (OFS_W'(n_outer) + OFS_W'(iprc_pkg::ICMP_HDR_BYTES));

    always_comb begin
        priority if (res_short) begin
            res_status = iprc_pkg::ST_SHORT;
        end else if (n_type != iprc_pkg::TYPE_ECHO_REPLY &&
                     n_type != iprc_pkg::TYPE_TIME_EXCEEDED) begin
            res_status = iprc_pkg::ST_OTHER;
        end else if (!n_done) begin
            res_status = iprc_pkg::ST_SHORT;
        end else if (n_ident != r_exp_ident || n_seq != r_exp_seq) begin
            res_status = iprc_pkg::ST_MISMATCH;
        end else begin
            res_status = iprc_pkg::ST_OK;
        end
        res_kind = (res_status == iprc_pkg::ST_OK || res_status == iprc_pkg::ST_MISMATCH) &&
                   (n_type == iprc_pkg::TYPE_TIME_EXCEEDED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_outer <= '0;
            r_inner <= '0;
            r_type  <= '0;
            r_ident <= '0;
            r_seq   <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_done  <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_pos   <= '0;
                r_outer <= '0;
                r_inner <= '0;
                r_type  <= '0;
                r_ident <= '0;
                r_seq   <= '0;
                r_src   <= '0;
                r_dst   <= '0;
                r_done  <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_outer <= n_outer;
                r_inner <= n_inner;
                r_type  <= n_type;
                r_ident <= n_ident;
                r_seq   <= n_seq;
                r_src   <= n_src;
                r_dst   <= n_dst;
                r_done  <= n_done;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_go && r_s1_last) begin
            o_matched           <= (res_status == iprc_pkg::ST_OK);
            o_reply_kind        <= res_kind;
            o_responder_address <= n_src;
            o_local_address     <= n_dst;
            o_reached_target    <= (res_status == iprc_pkg::ST_OK) && (n_src == r_target);
            o_status            <= res_status;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/iprc_checker.sv */
// Port-level assertions for the ICMP probe reply classifier, bound to the top level.
`default_nettype none

module iprc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_matched,
    input wire logic        o_reply_kind,
    input wire logic [31:0] o_responder_address,
    input wire logic        o_reached_target,
    input wire logic [1:0]  o_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_matched_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_matched == (o_status == iprc_pkg::ST_OK)))
        else $error("matched disagrees with status");

    a_reached_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reached_target |-> o_matched)
        else $error("target reached without a match");

    a_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == iprc_pkg::ST_SHORT || o_status == iprc_pkg::ST_OTHER)
        |-> !o_reply_kind)
        else $error("reply kind set on a short or foreign packet");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_responder_address))
        else $error("stalled result dropped or changed");

endmodule

bind icmp_probe_reply_classifier iprc_checker u_iprc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_matched           (o_matched),
    .o_reply_kind        (o_reply_kind),
    .o_responder_address (o_responder_address),
    .o_reached_target    (o_reached_target),
    .o_status            (o_status)
);

`default_nettype wire
